// ----- hw/rtl/edd_pkg.sv -----
// ---------------------------------------------------------------------------
// edd_pkg - shared types and constants of the error diffusion dither
// Fixed-point constants, register indexes, control struct and the 16-bit
// saturation helpers used by the datapath and the top level.
// ---------------------------------------------------------------------------
package edd_pkg;

   // pixel values are 16 times the level, full scale is 16 * 255
   localparam int EDD_LEVEL_W = 8;
   localparam int EDD_ERR_W   = 16;
   localparam int EDD_WIDE_W  = 20;
   localparam logic signed [EDD_ERR_W-1:0] EDD_FULL_SCALE = 16'sd4080;
   localparam logic signed [EDD_ERR_W-1:0] EDD_THRESHOLD  = 16'sd2040;

   // configuration registers
   localparam int EDD_WIDTH_CSR_W  = 11;
   localparam int EDD_HEIGHT_CSR_W = 13;
   localparam int EDD_CSR_DATA_W   = 13;
   localparam int EDD_CSR_INDEX_W  = 1;
   localparam logic [EDD_WIDTH_CSR_W-1:0]  EDD_WIDTH_RESET  = 11'd640;
   localparam logic [EDD_HEIGHT_CSR_W-1:0] EDD_HEIGHT_RESET = 13'd480;
   localparam logic [EDD_HEIGHT_CSR_W-1:0] EDD_HEIGHT_CAP   = 13'd4096;

   localparam int EDD_ROW_W = 12;
   localparam int EDD_MAX_WIDTH_DEFAULT = 1024;

   typedef enum logic [EDD_CSR_INDEX_W-1:0] {
      EDD_CSR_FRAME_WIDTH  = 1'd0,
      EDD_CSR_FRAME_HEIGHT = 1'd1
   } edd_csr_type;

   // per-item position flags, settled when the item is accepted
   typedef struct packed {
      logic first_col;
      logic last_col;
      logic row_zero;
      logic eof;
   } edd_ctl_type;

   // sign extend a 16-bit value to the wide working width
   function automatic logic signed [EDD_WIDE_W-1:0] edd_ext(
      input logic signed [EDD_ERR_W-1:0] v
   );
      return {{(EDD_WIDE_W-EDD_ERR_W){v[EDD_ERR_W-1]}}, v};
   endfunction

   // clamp a wide value to 16-bit signed
   function automatic logic signed [EDD_ERR_W-1:0] edd_sat16(
      input logic signed [EDD_WIDE_W-1:0] v
   );
      if (v > 20'sd32767) begin
         return 16'sh7fff;
      end else if (v < -20'sd32768) begin
         return 16'sh8000;
      end
      return v[EDD_ERR_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/error_diffusion_dither.sv -----
// ---------------------------------------------------------------------------
// error_diffusion_dither - one-bit error diffusion dither, raster order
// Turns 8-bit intensities into dots, spreading the error to the neighbors
// on the right and in the row below through a line store.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one pixel level per item in raster order; rsp_* returns
//   one dot per item, with rsp_end_of_frame set on the frame's last pixel.
//   frame_width and frame_height are written through csr_* between items;
//   a change takes effect at the next pixel.
//   rsp_valid rises after the item passes the read stage and result register.
//   One item is taken every cycle while req_stall is low; the carry to the
//   right neighbor loops through the threshold and share logic.
//   The line store is read when an item is accepted and written when its
//   result is formed; same-column writes in flight are forwarded.
//   When rsp_stall is high the result register holds and one more item
//   waits in the read stage; after that req_stall rises.
//   Reset clears the carries and counters and sets 640 by 480; the next
//   item is the first pixel of a frame. The line store is not cleared, as
//   row zero ignores what it reads.
// ---------------------------------------------------------------------------
module error_diffusion_dither
   import edd_pkg::*;
#(
   parameter int MAX_WIDTH = EDD_MAX_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [EDD_LEVEL_W-1:0]      req_pixel_level,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_dot_on,
   output logic                        rsp_end_of_frame,
   input  logic                        csr_write_enable,
   input  logic [EDD_CSR_INDEX_W-1:0]  csr_index,
   input  logic [EDD_CSR_DATA_W-1:0]   csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int LIM_W = (EDD_WIDTH_CSR_W > COL_W + 1) ? EDD_WIDTH_CSR_W : COL_W + 1;

   // configuration
   logic [EDD_WIDTH_CSR_W-1:0]  width_ff;
   logic [EDD_HEIGHT_CSR_W-1:0] height_ff;

   // position counters
   logic [COL_W-1:0]     col_ff, col_in;
   logic [EDD_ROW_W-1:0] row_ff, row_in;

   // read stage
   logic                        s1_valid_ff, s1_valid_in;
   logic [EDD_LEVEL_W-1:0]      s1_level_ff;
   logic [COL_W-1:0]            s1_col_ff;
   edd_ctl_type                 s1_ctl_ff;
   logic                        fwd_valid_ff, fwd_valid_in;
   logic signed [EDD_ERR_W-1:0] fwd_data_ff, fwd_data_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_dot_ff, rsp_eof_ff;

   // row-end write held for the next free write slot
   logic                        pend_valid_ff, pend_valid_in;
   logic [COL_W-1:0]            pend_addr_ff;
   logic signed [EDD_ERR_W-1:0] pend_data_ff;

   logic accept, advance;
   logic [LIM_W-1:0] w_ext, max_ext, w_eff, col_next;
   logic [EDD_HEIGHT_CSR_W-1:0] h_eff, row_next;
   edd_ctl_type ctl_now;

   logic                        main_we;
   logic                        wr_en;
   logic [COL_W-1:0]            wr_addr;
   logic signed [EDD_ERR_W-1:0] wr_data;
   logic signed [EDD_ERR_W-1:0] rd_data;
   logic signed [EDD_ERR_W-1:0] above;
   logic                        dot_on;
   logic signed [EDD_ERR_W-1:0] left_sum, below_sum;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= EDD_WIDTH_RESET;
         height_ff <= EDD_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            EDD_CSR_FRAME_WIDTH:  width_ff  <= csr_data[EDD_WIDTH_CSR_W-1:0];
            EDD_CSR_FRAME_HEIGHT: height_ff <= csr_data[EDD_HEIGHT_CSR_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // clamped frame size and position flags of the incoming item
   always_comb begin
      w_ext   = LIM_W'(width_ff);
      max_ext = LIM_W'(MAX_WIDTH);
      if (w_ext == '0) begin
         w_eff = LIM_W'(1);
      end else if (w_ext > max_ext) begin
         w_eff = max_ext;
      end else begin
         w_eff = w_ext;
      end
      if (height_ff == '0) begin
         h_eff = EDD_HEIGHT_CSR_W'(1);
      end else if (height_ff > EDD_HEIGHT_CAP) begin
         h_eff = EDD_HEIGHT_CAP;
      end else begin
         h_eff = height_ff;
      end
      col_next          = LIM_W'(col_ff) + LIM_W'(1);
      row_next          = EDD_HEIGHT_CSR_W'(row_ff) + EDD_HEIGHT_CSR_W'(1);
      ctl_now.first_col = (col_ff == '0);
      ctl_now.last_col  = (col_next >= w_eff);
      ctl_now.row_zero  = (row_ff == '0);
      ctl_now.eof       = ctl_now.last_col && (row_next >= h_eff);
   end

   // counters step on accept
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (ctl_now.last_col) begin
            col_in = '0;
            row_in = ctl_now.eof ? '0 : row_next[EDD_ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   // line store write port: left-below share, else the held row-end entry
   assign main_we = advance && !s1_ctl_ff.first_col;
   always_comb begin
      wr_en   = main_we || pend_valid_ff;
      wr_addr = main_we ? (s1_col_ff - COL_W'(1)) : pend_addr_ff;
      wr_data = main_we ? left_sum : pend_data_ff;
   end

   edd_line_store #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   // forward writes that land after the read was issued
   always_comb begin
      fwd_valid_in = fwd_valid_ff;
      fwd_data_in  = fwd_data_ff;
      if (accept) begin
         fwd_valid_in = wr_en && (wr_addr == col_ff);
         fwd_data_in  = wr_data;
      end else if (s1_valid_ff && wr_en && (wr_addr == s1_col_ff)) begin
         fwd_valid_in = 1'b1;
         fwd_data_in  = wr_data;
      end
   end

   // a row-end entry not yet written is the newest value of its column
   assign above = (pend_valid_ff && (pend_addr_ff == s1_col_ff)) ? pend_data_ff :
                  fwd_valid_ff ? fwd_data_ff : rd_data;

   edd_diffuse u_diffuse (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .level     (s1_level_ff),
      .above     (above),
      .ctl       (s1_ctl_ff),
      .dot_on    (dot_on),
      .left_sum  (left_sum),
      .below_sum (below_sum)
   );

   // stage and result valids, row-end write hold
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      pend_valid_in = pend_valid_ff && main_we;
      if (advance && s1_ctl_ff.last_col) begin
         pend_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fwd_data_ff <= fwd_data_in;
      if (accept) begin
         s1_level_ff <= req_pixel_level;
         s1_col_ff   <= col_ff;
         s1_ctl_ff   <= ctl_now;
      end
      if (advance) begin
         rsp_dot_ff <= dot_on;
         rsp_eof_ff <= s1_ctl_ff.eof;
      end
      if (advance && s1_ctl_ff.last_col) begin
         pend_addr_ff <= s1_col_ff;
         pend_data_ff <= below_sum;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dot_on       = rsp_dot_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

endmodule

// ----- hw/rtl/edd_line_store.sv -----
// ---------------------------------------------------------------------------
// edd_line_store - error line store
// One write port and one read port, read data registered.
// Holds the errors passed down to the next row, one entry per column.
// ---------------------------------------------------------------------------
module edd_line_store
   import edd_pkg::*;
#(
   parameter int DEPTH  = EDD_MAX_WIDTH_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic signed [EDD_ERR_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic signed [EDD_ERR_W-1:0] rd_data
);

   logic signed [EDD_ERR_W-1:0] mem [DEPTH];
   logic signed [EDD_ERR_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/edd_diffuse.sv -----
// ---------------------------------------------------------------------------
// edd_diffuse - threshold and error split
// Adds the carried and stored errors to the pixel, picks the dot and splits
// the error 7/3/5/1 sixteenths; keeps the carries along the current row.
// ---------------------------------------------------------------------------
module edd_diffuse
   import edd_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [EDD_LEVEL_W-1:0]        level,
   input  logic signed [EDD_ERR_W-1:0]   above,
   input  edd_ctl_type                   ctl,
   output logic                          dot_on,
   output logic signed [EDD_ERR_W-1:0]   left_sum,
   output logic signed [EDD_ERR_W-1:0]   below_sum
);

   logic signed [EDD_ERR_W-1:0]  right_carry_ff, right_carry_in;
   logic signed [EDD_ERR_W-1:0]  below_left_ff, below_left_in;
   logic signed [EDD_ERR_W-1:0]  below_ff, below_in;

   logic signed [EDD_ERR_W-1:0]  above_eff;
   logic signed [EDD_WIDE_W-1:0] sum_wide;
   logic signed [EDD_ERR_W-1:0]  old_val;
   logic signed [EDD_WIDE_W-1:0] diff_wide;
   logic signed [EDD_ERR_W-1:0]  err;
   logic signed [EDD_WIDE_W-1:0] err_w, m7, m3, m5;
   logic signed [EDD_ERR_W-1:0]  s7, s3, s5, s1;

   // pixel plus carried errors, then threshold
   always_comb begin
      above_eff = ctl.row_zero ? '0 : above;
      sum_wide  = $signed({{(EDD_WIDE_W-EDD_LEVEL_W-4){1'b0}}, level, 4'b0000})
                + edd_ext(right_carry_ff) + edd_ext(above_eff);
      old_val   = edd_sat16(sum_wide);
      dot_on    = (old_val > EDD_THRESHOLD);
      diff_wide = edd_ext(old_val) - (dot_on ? edd_ext(EDD_FULL_SCALE) : '0);
      err       = edd_sat16(diff_wide);
   end

   // shares by shift and add, floored by arithmetic shift
   always_comb begin
      err_w = edd_ext(err);
      m7    = (err_w <<< 3) - err_w;
      m3    = (err_w <<< 1) + err_w;
      m5    = (err_w <<< 2) + err_w;
      s7    = $signed(m7[EDD_WIDE_W-1:4]);
      s3    = $signed(m3[EDD_WIDE_W-1:4]);
      s5    = $signed(m5[EDD_WIDE_W-1:4]);
      s1    = {{4{err[EDD_ERR_W-1]}}, err[EDD_ERR_W-1:4]};
      left_sum  = edd_sat16(edd_ext(below_left_ff) + edd_ext(s3));
      below_sum = edd_sat16(edd_ext(below_ff) + edd_ext(s5));
   end

   // carries along the row, cleared at row end
   always_comb begin
      right_carry_in = right_carry_ff;
      below_left_in  = below_left_ff;
      below_in       = below_ff;
      if (advance) begin
         if (ctl.last_col) begin
            right_carry_in = '0;
            below_left_in  = '0;
            below_in       = '0;
         end else begin
            right_carry_in = s7;
            below_left_in  = below_sum;
            below_in       = s1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         right_carry_ff <= '0;
         below_left_ff  <= '0;
         below_ff       <= '0;
      end else begin
         right_carry_ff <= right_carry_in;
         below_left_ff  <= below_left_in;
         below_ff       <= below_in;
      end
   end

endmodule
